>>> hw/rtl/i2cseq_pkg.sv
// Shared types and codes for the I2C master transaction sequencer.
`default_nettype none

package i2cseq_pkg;

  // Input transaction kinds.
  typedef enum logic [1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  // Bus engine status codes.
  localparam logic [3:0] ST_START_SENT   = 4'd0;
  localparam logic [3:0] ST_RESTART_SENT = 4'd1;
  localparam logic [3:0] ST_ADDRW_ACK    = 4'd2;
  localparam logic [3:0] ST_ADDRW_NACK   = 4'd3;
  localparam logic [3:0] ST_DATA_ACK     = 4'd4;
  localparam logic [3:0] ST_DATA_NACK    = 4'd5;
  localparam logic [3:0] ST_ARB_LOST     = 4'd6;
  localparam logic [3:0] ST_ADDRR_ACK    = 4'd7;
  localparam logic [3:0] ST_ADDRR_NACK   = 4'd8;
  localparam logic [3:0] ST_RXDATA_ACK   = 4'd9;
  localparam logic [3:0] ST_RXDATA_NACK  = 4'd10;

  // Commands to the bus engine.
  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_CONT      = 3'd1,
    CMD_CONT_ACK  = 3'd2,
    CMD_START     = 3'd3,
    CMD_START_ACK = 3'd4,
    CMD_STOP      = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] target_address;
    logic [4:0] write_count;
    logic [4:0] read_count;
    logic [3:0] load_index;
    logic [7:0] load_byte;
    logic [3:0] bus_status;
    logic [7:0] bus_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0] command;
    logic       drive_valid;
    logic [7:0] drive_byte;
    logic       store_valid;
    logic [3:0] store_index;
    logic [7:0] store_byte;
    logic       busy_res;
  } out_item_t;

  // Write port of the transmit store.
  typedef struct packed {
    logic       we;
    logic [7:0] wd;
  } store_wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/i2c_master_transaction_sequencer.sv
// Top level of the I2C master write-then-read transaction sequencer.
`default_nettype none

// Usage
//   Input channel (in_valid/in_ready/in_data) carries three transaction kinds:
//   begin (latch address and counts, answer start), load (write one transmit
//   store slot) and bus status (advance the write-then-read sequence).
//   Result channel (out_valid/out_ready/out_data) returns exactly one result
//   per input transaction, in order: command, byte to drive, received byte to
//   store, and a busy flag.
// Timing
//   A transaction is accepted into the input register, decoded there and
//   lands in the result register once that register is free.
//   Throughput is 1 transaction per cycle while out_ready stays high; the
//   only loop is the state update in the decode stage.
//   The transmit store has a registered read that always presents the slot
//   at the current transmit position, so the decode stage never waits on it.
// Reset
//   rst_n is synchronous, active low: both stages empty, address, counters
//   and positions cleared. Store contents are not cleared.
// Backpressure
//   With out_ready low the result register holds; the input register still
//   takes one more transaction, then in_ready drops until the result drains.

module i2c_master_transaction_sequencer #(
  parameter int MAX_BYTES = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire i2cseq_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire                        out_ready,
  output i2cseq_pkg::out_item_t      out_data
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int PW = $clog2(MAX_BYTES + 1);
  localparam int CAP = (MAX_BYTES > 31) ? 31 : MAX_BYTES;
  localparam logic [4:0] CNT_CAP = 5'(CAP);

  // Pipeline registers
  logic                  in_vld_r;
  i2cseq_pkg::in_item_t  in_item_r;
  logic                  out_vld_r;
  i2cseq_pkg::out_item_t out_item_r;
  logic                  adv;

  // Sequencer state
  logic [6:0]    slave_addr_r, slave_addr_nxt;
  logic [4:0]    tx_left_r, tx_left_nxt;
  logic [4:0]    rx_left_r, rx_left_nxt;
  logic [PW-1:0] tx_pos_r, tx_pos_nxt;
  logic [3:0]    rx_pos_r, rx_pos_nxt;

  i2cseq_pkg::out_item_t res;
  i2cseq_pkg::store_wr_t st_wr;
  logic [AW-1:0]         st_wa;
  logic [AW-1:0]         st_ra;
  logic [7:0]            tx_byte;

  // Decode stage moves when it holds a transaction and the result slot frees
  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= '0;
      tx_left_r    <= '0;
      rx_left_r    <= '0;
      tx_pos_r     <= '0;
      rx_pos_r     <= '0;
    end else begin
      slave_addr_r <= slave_addr_nxt;
      tx_left_r    <= tx_left_nxt;
      rx_left_r    <= rx_left_nxt;
      tx_pos_r     <= tx_pos_nxt;
      rx_pos_r     <= rx_pos_nxt;
    end
  end

  // Store write from a load transaction; out-of-range slots are dropped
  always_comb begin
    st_wr.we = adv && (in_item_r.kind == i2cseq_pkg::KIND_LOAD) &&
               (int'(in_item_r.load_index) < MAX_BYTES);
    st_wr.wd = in_item_r.load_byte;
    st_wa    = AW'(in_item_r.load_index);
    st_ra    = (int'(tx_pos_nxt) < MAX_BYTES) ? tx_pos_nxt[AW-1:0] : '0;
  end

  i2cseq_tx_store #(
    .DEPTH (MAX_BYTES),
    .AW    (AW)
  ) u_tx_store (
    .clk  (clk),
    .wr   (st_wr),
    .wa   (st_wa),
    .ra   (st_ra),
    .rd_r (tx_byte)
  );

  // Decode and state update
  always_comb begin
    slave_addr_nxt = slave_addr_r;
    tx_left_nxt    = tx_left_r;
    rx_left_nxt    = rx_left_r;
    tx_pos_nxt     = tx_pos_r;
    rx_pos_nxt     = rx_pos_r;

    res.command     = i2cseq_pkg::CMD_NONE;
    res.drive_valid = 1'b0;
    res.drive_byte  = '0;
    res.store_valid = 1'b0;
    res.store_index = '0;
    res.store_byte  = '0;

    if (adv) begin
      case (in_item_r.kind)
        i2cseq_pkg::KIND_BEGIN: begin
          slave_addr_nxt = in_item_r.target_address;
          tx_left_nxt = (in_item_r.write_count > CNT_CAP) ? CNT_CAP : in_item_r.write_count;
          rx_left_nxt = (in_item_r.read_count > CNT_CAP) ? CNT_CAP : in_item_r.read_count;
          tx_pos_nxt  = '0;
          rx_pos_nxt  = '0;
          res.command = i2cseq_pkg::CMD_START;
        end
        i2cseq_pkg::KIND_STATUS: begin
          case (in_item_r.bus_status)
            i2cseq_pkg::ST_START_SENT: begin
              res.drive_valid = 1'b1;
              res.drive_byte  = {slave_addr_r, 1'b0};
              res.command     = i2cseq_pkg::CMD_CONT;
            end
            i2cseq_pkg::ST_RESTART_SENT: begin
              res.drive_valid = 1'b1;
              res.drive_byte  = {slave_addr_r, 1'b1};
              res.command     = i2cseq_pkg::CMD_CONT;
            end
            i2cseq_pkg::ST_ADDRW_ACK, i2cseq_pkg::ST_DATA_ACK: begin
              if (tx_left_r != '0) begin
                tx_left_nxt     = tx_left_r - 5'd1;
                tx_pos_nxt      = tx_pos_r + PW'(1);
                res.drive_valid = 1'b1;
                res.drive_byte  = tx_byte;
                res.command     = i2cseq_pkg::CMD_CONT;
              end else if (rx_left_r != '0) begin
                res.command = i2cseq_pkg::CMD_START_ACK;
              end else begin
                res.command = i2cseq_pkg::CMD_STOP;
              end
            end
            i2cseq_pkg::ST_ADDRR_ACK: begin
              res.command = i2cseq_pkg::CMD_CONT_ACK;
            end
            i2cseq_pkg::ST_RXDATA_ACK: begin
              // nothing left to count: extra byte, dropped
              if (rx_left_r != '0) begin
                rx_left_nxt     = rx_left_r - 5'd1;
                rx_pos_nxt      = rx_pos_r + 4'd1;
                res.store_valid = 1'b1;
                res.store_index = rx_pos_r;
                res.store_byte  = in_item_r.bus_data;
                res.command     = (rx_left_r > 5'd1) ? i2cseq_pkg::CMD_CONT_ACK
                                                     : i2cseq_pkg::CMD_CONT;
              end
            end
            default: begin
              // any NACK, arbitration loss, unknown status
              res.command = i2cseq_pkg::CMD_STOP;
            end
          endcase
        end
        default: begin
          // load transaction and unused kind answer none
        end
      endcase
    end

    res.busy_res = (tx_left_nxt != '0) || (rx_left_nxt != '0);
  end

endmodule

`default_nettype wire

>>> hw/rtl/i2cseq_tx_store.sv
// Transmit byte store: one write port, one registered read port with write bypass.
`default_nettype none

module i2cseq_tx_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire                       clk,
  input  wire i2cseq_pkg::store_wr_t wr,
  input  wire [AW-1:0]              wa,
  input  wire [AW-1:0]              ra,
  output logic [7:0]                rd_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wa] <= wr.wd;
    end
  end

  // rd_r always mirrors the entry at ra as of after this cycle's write
  always_ff @(posedge clk) begin
    if (wr.we && (wa == ra)) begin
      rd_r <= wr.wd;
    end else begin
      rd_r <= mem[ra];
    end
  end

endmodule

`default_nettype wire

>>> dv/i2c_master_transaction_sequencer_tb.sv
// Self-checking testbench for the I2C master write-then-read transaction sequencer.
`timescale 1ns / 100ps

module i2c_master_transaction_sequencer_tb;

  // Transaction kind 3 has no name in the package; the block must ignore it.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Status codes 11..15 are unknown to the block and must answer stop.
  localparam logic [3:0] ST_OTHER    = 4'd11;
  localparam logic [3:0] ST_LAST     = 4'd15;

  localparam int MAX_BYTES    = 16;
  localparam int RANDOM_TXNS  = 500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;       // drain of the pipe plus margin
  localparam int HOLD_CYCLES  = 48;      // long receiver stall for the fill-up test

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  i2cseq_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_ready;
  i2cseq_pkg::out_item_t out_data;

  i2c_master_transaction_sequencer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Predicted sequencer state. Mirrors the block: latched address, bytes left in
  // each direction, positions in each direction and the transmit byte store.
  // slot_loaded tracks which store slots hold a defined byte so the stimulus
  // never makes the block transmit an unwritten slot.
  // ---------------------------------------------------------------------------
  logic [6:0] pred_addr    = '0;
  logic [4:0] pred_tx_left = '0;
  logic [4:0] pred_rx_left = '0;
  logic [3:0] pred_tx_pos  = '0;
  logic [3:0] pred_rx_pos  = '0;
  logic [7:0] tx_bytes [MAX_BYTES];
  bit         slot_loaded [MAX_BYTES];

  i2cseq_pkg::out_item_t expected_results [$];

  int  txn_count          = 0;   // transactions accepted on the input side
  int  result_count       = 0;   // results taken on the output side
  int  mismatch_count     = 0;
  int  input_stall_cycles = 0;   // cycles with in_valid high and in_ready low
  int  cycle_count        = 0;

  bit  tx_idle_en    = 1'b1;     // sender inserts random gaps
  bit  rx_idle_en    = 1'b1;     // receiver inserts random stalls
  int  rx_hold_cycles = 0;       // request for one long receiver hold-off

  // Apply one transaction to the predicted state and return its result.
  function automatic i2cseq_pkg::out_item_t predict_result(input i2cseq_pkg::in_item_t t);
    i2cseq_pkg::out_item_t r;
    r = '0;
    r.command = i2cseq_pkg::CMD_NONE;
    case (t.kind)
      i2cseq_pkg::KIND_BEGIN: begin
        pred_addr    = t.target_address;
        pred_tx_left = (t.write_count > MAX_BYTES) ? 5'(MAX_BYTES) : t.write_count;
        pred_rx_left = (t.read_count > MAX_BYTES) ? 5'(MAX_BYTES) : t.read_count;
        pred_tx_pos  = '0;
        pred_rx_pos  = '0;
        r.command    = i2cseq_pkg::CMD_START;
      end
      i2cseq_pkg::KIND_LOAD: begin
        tx_bytes[t.load_index]    = t.load_byte;
        slot_loaded[t.load_index] = 1'b1;
      end
      i2cseq_pkg::KIND_STATUS: begin
        case (t.bus_status)
          i2cseq_pkg::ST_START_SENT: begin
            r.drive_valid = 1'b1;
            r.drive_byte  = {pred_addr, 1'b0};
            r.command     = i2cseq_pkg::CMD_CONT;
          end
          i2cseq_pkg::ST_RESTART_SENT: begin
            r.drive_valid = 1'b1;
            r.drive_byte  = {pred_addr, 1'b1};
            r.command     = i2cseq_pkg::CMD_CONT;
          end
          i2cseq_pkg::ST_ADDRW_ACK, i2cseq_pkg::ST_DATA_ACK: begin
            // Next transmit byte; once those are gone, restart for the read
            // phase or stop if there is nothing to read.
            if (pred_tx_left != '0) begin
              pred_tx_left  = pred_tx_left - 5'd1;
              r.drive_valid = 1'b1;
              r.drive_byte  = tx_bytes[pred_tx_pos];
              pred_tx_pos   = pred_tx_pos + 4'd1;
              r.command     = i2cseq_pkg::CMD_CONT;
            end else if (pred_rx_left != '0) begin
              r.command = i2cseq_pkg::CMD_START_ACK;
            end else begin
              r.command = i2cseq_pkg::CMD_STOP;
            end
          end
          i2cseq_pkg::ST_ADDRR_ACK: r.command = i2cseq_pkg::CMD_CONT_ACK;
          i2cseq_pkg::ST_RXDATA_ACK: begin
            // Nothing left to receive: no command, nothing stored.
            if (pred_rx_left != '0) begin
              pred_rx_left  = pred_rx_left - 5'd1;
              r.store_valid = 1'b1;
              r.store_index = pred_rx_pos;
              r.store_byte  = t.bus_data;
              pred_rx_pos   = pred_rx_pos + 4'd1;
              // The last counted byte is followed by one NACKed throwaway read.
              r.command     = (pred_rx_left != '0) ? i2cseq_pkg::CMD_CONT_ACK
                                                   : i2cseq_pkg::CMD_CONT;
            end
          end
          // Every NACK, arbitration loss and unknown code stops the bus.
          // Counters stay as they are, so busy stays up until the next begin.
          default: r.command = i2cseq_pkg::CMD_STOP;
        endcase
      end
      default: ;  // unused kind: no effect
    endcase
    r.busy_res = (pred_tx_left != '0) || (pred_rx_left != '0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results still pending", $time,
             cycle_count, expected_results.size());
    $display("i2c_master_transaction_sequencer_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result checking. Values are sampled at the rising edge, before the block's
  // own updates for that edge land, so a handshake is seen exactly once.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  task automatic check_result(input i2cseq_pkg::out_item_t got);
    i2cseq_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result, expected none actual %h", $time, got);
      return;
    end
    want = expected_results.pop_front();
    compare_field("command",     8'(want.command),     8'(got.command));
    compare_field("drive_valid", 8'(want.drive_valid), 8'(got.drive_valid));
    compare_field("drive_byte",  want.drive_byte,      got.drive_byte);
    compare_field("store_valid", 8'(want.store_valid), 8'(got.store_valid));
    compare_field("store_index", 8'(want.store_index), 8'(got.store_index));
    compare_field("store_byte",  want.store_byte,      got.store_byte);
    compare_field("busy_res",    8'(want.busy_res),    8'(got.busy_res));
  endtask

  initial begin : result_monitor
    forever begin
      @(posedge clk);
      if (rst_n && in_valid && !in_ready) input_stall_cycles++;
      if (rst_n && out_valid && out_ready) begin
        result_count++;
        check_result(out_data);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a random stall before each result, stretches with no stalls, and
  // on request one long hold-off counted here so the block backs up.
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        while (rx_hold_cycles > 0) begin
          @(posedge clk);
          rx_hold_cycles--;
        end
      end
      stall = rx_idle_en ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && rx_hold_cycles == 0);
      if ($urandom_range(0, 39) == 0) rx_idle_en = !rx_idle_en;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Entered right after a rising edge; valid is only lowered when a
  // gap follows, so back-to-back transactions keep it high.
  // ---------------------------------------------------------------------------
  task automatic send_txn(input i2cseq_pkg::in_item_t t);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    txn_count++;
    expected_results.push_back(predict_result(t));
  endtask

  // Fields the kind does not use are left random.
  function automatic i2cseq_pkg::in_item_t random_txn(input logic [1:0] kind);
    i2cseq_pkg::in_item_t t;
    logic [63:0]          raw;
    raw    = {$urandom, $urandom};
    t      = raw[$bits(i2cseq_pkg::in_item_t)-1:0];
    t.kind = kind;
    return t;
  endfunction

  // Any transmit read of a slot never loaded gets a load of that slot first.
  task automatic issue_txn(input i2cseq_pkg::in_item_t t);
    i2cseq_pkg::in_item_t fill;
    if (t.kind == i2cseq_pkg::KIND_STATUS &&
        (t.bus_status == i2cseq_pkg::ST_ADDRW_ACK ||
         t.bus_status == i2cseq_pkg::ST_DATA_ACK) &&
        pred_tx_left != '0 && !slot_loaded[pred_tx_pos]) begin
      fill = random_txn(i2cseq_pkg::KIND_LOAD);
      fill.load_index = pred_tx_pos;
      send_txn(fill);
    end
    send_txn(t);
  endtask

  task automatic issue_begin(input logic [6:0] addr, input logic [4:0] wr_n,
                             input logic [4:0] rd_n);
    i2cseq_pkg::in_item_t t;
    t = random_txn(i2cseq_pkg::KIND_BEGIN);
    t.target_address = addr;
    t.write_count    = wr_n;
    t.read_count     = rd_n;
    issue_txn(t);
  endtask

  task automatic issue_load(input logic [3:0] idx, input logic [7:0] b);
    i2cseq_pkg::in_item_t t;
    t = random_txn(i2cseq_pkg::KIND_LOAD);
    t.load_index = idx;
    t.load_byte  = b;
    issue_txn(t);
  endtask

  task automatic issue_status(input logic [3:0] st, input logic [7:0] data);
    i2cseq_pkg::in_item_t t;
    t = random_txn(i2cseq_pkg::KIND_STATUS);
    t.bus_status = st;
    t.bus_data   = data;
    issue_txn(t);
  endtask

  // With the given chance, inject a fully random transaction (any kind, any
  // status code); half of those end the current transfer.
  task automatic inject_noise(input int pct, output bit aborted);
    aborted = 1'b0;
    if ($urandom_range(0, 99) < pct) begin
      issue_txn(random_txn(2'($urandom_range(0, 3))));
      aborted = 1'($urandom_range(0, 1));
    end
  endtask

  // Mostly short transfers, some up to the store size, a few past it.
  function automatic logic [4:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 5'($urandom_range(0, 4));
    if (r < 95) return 5'($urandom_range(5, MAX_BYTES));
    return 5'($urandom_range(MAX_BYTES + 1, 31));
  endfunction

  // One write-then-read transfer as the bus engine would report it.
  task automatic run_transfer(input logic [6:0] addr, input logic [4:0] wr_n,
                              input logic [4:0] rd_n, input int noise_pct);
    bit aborted;
    bit more;
    int n;
    issue_begin(addr, wr_n, rd_n);
    n = (wr_n > MAX_BYTES) ? MAX_BYTES : int'(wr_n);
    if ($urandom_range(0, 1) == 0)
      for (int i = 0; i < n; i++) issue_load(4'(i), 8'($urandom));
    inject_noise(noise_pct, aborted);
    if (aborted) return;
    issue_status(i2cseq_pkg::ST_START_SENT, 8'($urandom));
    // Address ack sends the first byte, each data ack the next; the ack after
    // the last byte turns to the read phase or stops.
    do begin
      inject_noise(noise_pct, aborted);
      if (aborted) return;
      more = (pred_tx_left != '0);
      // Load right before the read of the same slot now and then.
      if (more && $urandom_range(0, 3) == 0) issue_load(pred_tx_pos, 8'($urandom));
      issue_status((pred_tx_pos == '0 && more) ? i2cseq_pkg::ST_ADDRW_ACK
                                               : i2cseq_pkg::ST_DATA_ACK, 8'($urandom));
    end while (more);
    if (pred_rx_left == '0) return;
    issue_status(i2cseq_pkg::ST_RESTART_SENT, 8'($urandom));
    inject_noise(noise_pct, aborted);
    if (aborted) return;
    issue_status(i2cseq_pkg::ST_ADDRR_ACK, 8'($urandom));
    while (pred_rx_left != '0) begin
      inject_noise(noise_pct, aborted);
      if (aborted) return;
      issue_status(i2cseq_pkg::ST_RXDATA_ACK, 8'($urandom));
    end
    // Occasionally an ack past the end of the read count.
    if ($urandom_range(0, 7) == 0) issue_status(i2cseq_pkg::ST_RXDATA_ACK, 8'($urandom));
    issue_status(i2cseq_pkg::ST_RXDATA_NACK, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Status events with no transfer set up, the unused kind and unknown codes.
  task automatic test_idle_status_events();
    issue_txn('1);                     // unused kind, every other bit set
    issue_status(i2cseq_pkg::ST_RXDATA_ACK, 8'hFF); // nothing left to receive
    issue_status(ST_OTHER, 8'h00);
    issue_status(i2cseq_pkg::ST_DATA_ACK, 8'hA5);   // no bytes either way: stop
    issue_txn('0);                     // begin with zero address and counts
  endtask

  // A complete transfer: two bytes out, two in, extreme address and data.
  task automatic test_write_then_read();
    issue_load(4'd0, 8'h00);
    issue_load(4'd1, 8'hFF);
    issue_begin(7'h7F, 5'd2, 5'd2);
    issue_status(i2cseq_pkg::ST_START_SENT, 8'h00);
    issue_status(i2cseq_pkg::ST_ADDRW_ACK, 8'h00);
    issue_status(i2cseq_pkg::ST_DATA_ACK, 8'h00);
    issue_status(i2cseq_pkg::ST_DATA_ACK, 8'h00);
    issue_status(i2cseq_pkg::ST_RESTART_SENT, 8'h00);
    issue_status(i2cseq_pkg::ST_ADDRR_ACK, 8'h00);
    issue_status(i2cseq_pkg::ST_RXDATA_ACK, 8'hFF);
    issue_status(i2cseq_pkg::ST_RXDATA_ACK, 8'h00);
    issue_status(i2cseq_pkg::ST_RXDATA_NACK, 8'h5A);
  endtask

  // Counts past the store size saturate; NACKs and arbitration loss stop with
  // busy left high.
  task automatic test_aborts_and_saturation();
    issue_begin(7'h00, 5'd31, 5'd17);
    issue_status(i2cseq_pkg::ST_START_SENT, 8'hFF);
    issue_status(i2cseq_pkg::ST_ADDRW_NACK, 8'hFF);
    issue_status(i2cseq_pkg::ST_DATA_NACK, 8'h00);
    issue_status(i2cseq_pkg::ST_ARB_LOST, 8'h00);
    issue_status(i2cseq_pkg::ST_ADDRR_NACK, 8'h00);
    issue_status(ST_LAST, 8'hFF);
  endtask

  // Receiver holds off while transactions arrive back to back: the block fills
  // and must stall its input without losing or reordering anything.
  task automatic test_output_backpressure();
    tx_idle_en     = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    run_transfer(7'($urandom), 5'd8, 5'd8, 0);
    tx_idle_en     = 1'b1;
  endtask

  task automatic test_random_transfers();
    int stop_at;
    stop_at = txn_count + RANDOM_TXNS;
    while (txn_count < stop_at) begin
      tx_idle_en = ($urandom_range(0, 3) != 0);
      run_transfer(7'($urandom), pick_count(), pick_count(),
                   ($urandom_range(0, 4) == 0) ? 25 : 3);
    end
    tx_idle_en = 1'b1;
  endtask

  initial begin : main
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_status_events();
    test_write_then_read();
    test_aborts_and_saturation();
    test_output_backpressure();
    test_random_transfers();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d transactions through begin, load and status sequences, %0d results",
             txn_count, result_count);
    $display("checked; input held off by backpressure for %0d cycles, %0d mismatches.",
             input_stall_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("i2c_master_transaction_sequencer_tb passed");
    end else begin
      $display("i2c_master_transaction_sequencer_tb failed");
    end
    $finish;
  end

endmodule

>>> i2c_master_transaction_sequencer.f
hw/rtl/i2cseq_pkg.sv
hw/rtl/i2cseq_tx_store.sv
hw/rtl/i2c_master_transaction_sequencer.sv
dv/i2c_master_transaction_sequencer_tb.sv
